// ----- hw/rtl/sfpc_pkg.sv -----
package sfpc_pkg;

  // Framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] KIND_D1     = 8'hD1;
  localparam logic [7:0] KIND_D2     = 8'hD2;
  localparam logic [7:0] KIND_D3     = 8'hD3;
  localparam logic [7:0] KIND_D4     = 8'hD4;
  localparam logic [7:0] KIND_D5     = 8'hD5;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_KIND  = 2'd1,
    PH_DATA  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  // One accepted frame
  typedef struct packed {
    logic [7:0]  frame_kind;
    logic [1:0]  payload_length;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
    logic [7:0]  payload_third;
    logic [31:0] frame_number;
  } sfpc_result_t;

  // Payload length for an identifier, zero when the identifier is unknown
  function automatic logic [1:0] kind_length(input logic [7:0] kind);
    logic [1:0] len;
    case (kind)
      KIND_D1, KIND_D2, KIND_D5: len = 2'd3;
      KIND_D3:                   len = 2'd1;
      KIND_D4:                   len = 2'd2;
      default:                   len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/sfpc_if.sv -----
// Received byte channel
interface sfpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Accepted frame channel
interface sfpc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_kind;
  logic [1:0]  payload_length;
  logic [7:0]  payload_first;
  logic [7:0]  payload_second;
  logic [7:0]  payload_third;
  logic [31:0] frame_number;

  modport source (output valid, output frame_kind, output payload_length,
                  output payload_first, output payload_second,
                  output payload_third, output frame_number, input ready);
  modport sink   (input valid, input frame_kind, input payload_length,
                  input payload_first, input payload_second,
                  input payload_third, input frame_number, output ready);
endinterface

// ----- hw/rtl/sfpc_parser.sv -----
module sfpc_parser
  import sfpc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         emit,
  output sfpc_result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  store_r [3];
  logic [1:0]  id_len;
  logic [7:0]  sum_add;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload bytes, no reset: only bytes of the current frame are read
  always_ff @(posedge clk) begin
    if (step && phase_r == PH_DATA && idx_r != 2'd3) begin
      store_r[idx_r] <= rx_byte;
    end
  end

  assign id_len  = kind_length(rx_byte);
  assign sum_add = sum_r + rx_byte;

  // Next state and frame result
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    emit      = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == HEADER_BYTE) begin
          phase_nxt = PH_KIND;
          sum_nxt   = rx_byte;
        end
      end
      PH_KIND: begin
        kind_nxt = rx_byte;
        if (id_len == 2'd0) begin
          phase_nxt = PH_HUNT;
        end else begin
          len_nxt   = id_len;
          sum_nxt   = sum_add;
          idx_nxt   = 2'd0;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        idx_nxt = idx_r + 2'd1;
        sum_nxt = sum_add;
        if ({1'b0, idx_r} + 3'd1 >= {1'b0, len_r}) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        phase_nxt = PH_HUNT;
        if (sum_r == rx_byte) begin
          emit      = 1'b1;
          count_nxt = count_r + 32'd1;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // Unused payload bytes read as zero
  always_comb begin
    res.frame_kind     = kind_r;
    res.payload_length = len_r;
    res.payload_first  = (len_r >= 2'd1) ? store_r[0] : 8'd0;
    res.payload_second = (len_r >= 2'd2) ? store_r[1] : 8'd0;
    res.payload_third  = (len_r >= 2'd3) ? store_r[2] : 8'd0;
    res.frame_number   = count_r + 32'd1;
  end

  // A frame is counted exactly when it is emitted
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (count_r == $past(count_r) + {31'd0, $past(emit)}))
    else $error("frame count out of step with emitted frames");

  // The checksum byte always ends the frame
  a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_CHECK) |=> phase_r == PH_HUNT)
    else $error("parser did not return to hunting after checksum");

  // Payload is only read for a known identifier
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != 2'd0))
    else $error("reading payload with zero length");

endmodule

// ----- hw/rtl/serial_frame_parser_checksum.sv -----
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    rx_byte
// out_ch   out  valid/ready    frame_kind, payload_length, payload_first,
//                              payload_second, payload_third, frame_number
//
// One byte per cycle sustained while out_ch is ready; a byte passes the input
// register and the parser logic into the result register, so out_ch.valid
// rises once the checksum byte has reached the result register.
// Reset is synchronous on rst_n: parser returns to hunting, count clears.
// A result waiting in the output register stalls the parser until
// out_ch.ready is high; the input register still fills while it is empty.
module serial_frame_parser_checksum
  import sfpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sfpc_in_if.sink           in_ch,
  sfpc_out_if.source        out_ch
);

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         out_vld_r;
  sfpc_result_t out_res_r;
  logic         out_free;
  logic         proc;
  logic         emit;
  sfpc_result_t res;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign proc        = in_vld_r && out_free;
  assign in_ch.ready = !in_vld_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  sfpc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .rx_byte (in_byte_r),
    .emit    (emit),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.frame_kind     = out_res_r.frame_kind;
  assign out_ch.payload_length = out_res_r.payload_length;
  assign out_ch.payload_first  = out_res_r.payload_first;
  assign out_ch.payload_second = out_res_r.payload_second;
  assign out_ch.payload_third  = out_res_r.payload_third;
  assign out_ch.frame_number   = out_res_r.frame_number;

  // A new result only follows a processed byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_vld_r))
    else $error("result appeared without a processed byte");

  // Emitted frames always carry a known length
  a_length_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.payload_length == 2'd1 ||
                   out_res_r.payload_length == 2'd2 ||
                   out_res_r.payload_length == 2'd3))
    else $error("emitted frame with zero length");

  // Bytes beyond the frame length are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.payload_length != 2'd3) |->
      (out_res_r.payload_third == 8'd0 &&
       (out_res_r.payload_length == 2'd2 || out_res_r.payload_second == 8'd0)))
    else $error("unused payload byte not zeroed");

endmodule
